>>> rtl/ucdef_pkg.sv
package ucdef_pkg;

    localparam int CfgIdxW = 1;
    localparam int CfgDataW = 16;

    localparam logic [CfgIdxW-1:0] CFG_DEVICE_VENDOR  = 1'b0;
    localparam logic [CfgIdxW-1:0] CFG_DEVICE_PRODUCT = 1'b1;

    localparam logic [7:0] DESC_TYPE_INTERFACE = 8'h04;
    localparam logic [7:0] DESC_TYPE_ENDPOINT  = 8'h05;
    localparam logic [7:0] ATTR_BULK           = 8'h02;
    localparam logic [7:0] MIN_DESC_LENGTH     = 8'h02;

    localparam logic [15:0] CDC_VENDOR     = 16'h2341;
    localparam logic [15:0] CDC_PRODUCT    = 16'h0001;
    localparam logic [15:0] BRIDGE_VENDOR  = 16'h0403;
    localparam logic [15:0] BRIDGE_PRODUCT = 16'h6001;

    localparam logic [7:0] OFF_LENGTH  = 8'd0;
    localparam logic [7:0] OFF_TYPE    = 8'd1;
    localparam logic [7:0] OFF_ADDRESS = 8'd2;
    localparam logic [7:0] OFF_ATTR    = 8'd3;

    typedef enum logic [1:0] {
        KIND_UNKNOWN = 2'd0,
        KIND_CDC     = 2'd1,
        KIND_BRIDGE  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        STATUS_FOUND     = 2'd0,
        STATUS_NOT_FOUND = 2'd1,
        STATUS_MALFORMED = 2'd2
    } t_status;

    function automatic t_kind kind_from_ids(input logic [15:0] vendor,
                                            input logic [15:0] product);
        t_kind k;
        k = KIND_UNKNOWN;
        if (vendor == CDC_VENDOR && product == CDC_PRODUCT) begin
            k = KIND_CDC;
        end else if (vendor == BRIDGE_VENDOR && product == BRIDGE_PRODUCT) begin
            k = KIND_BRIDGE;
        end
        return k;
    endfunction

endpackage

>>> rtl/ucdef_ifs.sv
interface ucdef_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ucdef_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [7:0] in_endpoint;
    logic [7:0] out_endpoint;
    logic [1:0] device_kind;

    modport source (output valid, output status, output in_endpoint,
                    output out_endpoint, output device_kind, input ready);
    modport sink (input valid, input status, input in_endpoint,
                  input out_endpoint, input device_kind, output ready);
endinterface

>>> rtl/usb_config_descriptor_endpoint_finder.sv
// a result is registered and appears in the cycle after the item carrying the last-byte mark is taken
// throughput: one byte item per cycle while the input is not held off, set by the combinational descriptor walk
// input is held off only while a finished result waits to be taken
// reset (synchronous, active low) clears the id registers, the walk state and
// the result valid flag; every set starts again with kind unknown
module usb_config_descriptor_endpoint_finder (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ucdef_pkg::CfgIdxW-1:0]       i_cfg_index,
    input  logic [ucdef_pkg::CfgDataW-1:0]      i_cfg_data,
    ucdef_in_if.sink                            i_in_item,
    ucdef_out_if.source                         o_out_item
);

    logic [15:0]      r_vendor;
    logic [15:0]      r_product;

    logic [7:0]       r_byte_offset, n_byte_offset;
    logic [7:0]       r_desc_length, n_desc_length;
    logic [7:0]       r_desc_type, n_desc_type;
    logic [7:0]       r_ep_address, n_ep_address;
    logic [7:0]       r_found_in, n_found_in;
    logic [7:0]       r_found_out, n_found_out;
    ucdef_pkg::t_kind r_kind, n_kind;
    logic             r_search_done, n_search_done;
    logic             r_malformed, n_malformed;

    logic             r_out_valid;
    ucdef_pkg::t_status r_out_status, n_out_status;
    logic [7:0]       r_out_in_ep;
    logic [7:0]       r_out_out_ep;
    ucdef_pkg::t_kind r_out_kind;

    logic             accept;
    logic             at_boundary;
    logic [8:0]       next_off_wide;
    logic [7:0]       b;

    assign i_in_item.ready = !r_out_valid || o_out_item.ready;
    assign accept          = i_in_item.valid && i_in_item.ready;
    assign b               = i_in_item.data_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vendor  <= '0;
            r_product <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ucdef_pkg::CFG_DEVICE_VENDOR:  r_vendor  <= i_cfg_data;
                ucdef_pkg::CFG_DEVICE_PRODUCT: r_product <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // one byte of the descriptor walk
    always_comb begin
        n_byte_offset = r_byte_offset;
        n_desc_length = r_desc_length;
        n_desc_type   = r_desc_type;
        n_ep_address  = r_ep_address;
        n_found_in    = r_found_in;
        n_found_out   = r_found_out;
        n_kind        = r_kind;
        n_search_done = r_search_done;
        n_malformed   = r_malformed;
        at_boundary   = 1'b1;
        next_off_wide = {1'b0, r_byte_offset} + 9'd1;

        if (!r_search_done && !r_malformed) begin
            case (r_byte_offset)
                ucdef_pkg::OFF_LENGTH: begin
                    n_desc_length = b;
                end
                ucdef_pkg::OFF_TYPE: begin
                    n_desc_type = b;
                    if (b == ucdef_pkg::DESC_TYPE_INTERFACE) begin
                        n_kind      = ucdef_pkg::kind_from_ids(r_vendor, r_product);
                        n_found_in  = '0;
                        n_found_out = '0;
                    end
                end
                ucdef_pkg::OFF_ADDRESS: begin
                    n_ep_address = b;
                end
                ucdef_pkg::OFF_ATTR: begin
                    if (r_desc_type == ucdef_pkg::DESC_TYPE_ENDPOINT
                        && r_kind != ucdef_pkg::KIND_UNKNOWN
                        && b == ucdef_pkg::ATTR_BULK) begin
                        if (r_ep_address[7]) begin
                            if (r_found_in == '0) n_found_in = r_ep_address;
                        end else begin
                            if (r_found_out == '0) n_found_out = r_ep_address;
                        end
                    end
                end
                default: ;
            endcase

            if (r_byte_offset == ucdef_pkg::OFF_LENGTH
                && b < ucdef_pkg::MIN_DESC_LENGTH) begin
                n_malformed = 1'b1;
                at_boundary = 1'b0;
            end else if (next_off_wide >= {1'b0, n_desc_length}) begin
                n_byte_offset = '0;
                at_boundary   = 1'b1;
            end else begin
                n_byte_offset = next_off_wide[7:0];
                at_boundary   = 1'b0;
            end

            if (at_boundary && n_found_in != '0 && n_found_out != '0) begin
                n_search_done = 1'b1;
            end
        end

        if (n_search_done) begin
            n_out_status = ucdef_pkg::STATUS_FOUND;
        end else if (n_malformed || !at_boundary) begin
            n_out_status = ucdef_pkg::STATUS_MALFORMED;
        end else begin
            n_out_status = ucdef_pkg::STATUS_NOT_FOUND;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_offset <= '0;
            r_desc_length <= '0;
            r_desc_type   <= '0;
            r_ep_address  <= '0;
            r_found_in    <= '0;
            r_found_out   <= '0;
            r_kind        <= ucdef_pkg::KIND_UNKNOWN;
            r_search_done <= 1'b0;
            r_malformed   <= 1'b0;
        end else if (accept) begin
            if (i_in_item.last_byte) begin
                r_byte_offset <= '0;
                r_desc_length <= '0;
                r_desc_type   <= '0;
                r_ep_address  <= '0;
                r_found_in    <= '0;
                r_found_out   <= '0;
                r_kind        <= ucdef_pkg::KIND_UNKNOWN;
                r_search_done <= 1'b0;
                r_malformed   <= 1'b0;
            end else begin
                r_byte_offset <= n_byte_offset;
                r_desc_length <= n_desc_length;
                r_desc_type   <= n_desc_type;
                r_ep_address  <= n_ep_address;
                r_found_in    <= n_found_in;
                r_found_out   <= n_found_out;
                r_kind        <= n_kind;
                r_search_done <= n_search_done;
                r_malformed   <= n_malformed;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && i_in_item.last_byte) begin
            r_out_valid <= 1'b1;
        end else if (o_out_item.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_in_item.last_byte) begin
            r_out_status <= n_out_status;
            r_out_kind   <= n_kind;
            if (n_out_status == ucdef_pkg::STATUS_MALFORMED) begin
                r_out_in_ep  <= '0;
                r_out_out_ep <= '0;
            end else begin
                r_out_in_ep  <= n_found_in;
                r_out_out_ep <= n_found_out;
            end
        end
    end

    assign o_out_item.valid        = r_out_valid;
    assign o_out_item.status       = r_out_status;
    assign o_out_item.in_endpoint  = r_out_in_ep;
    assign o_out_item.out_endpoint = r_out_out_ep;
    assign o_out_item.device_kind  = r_out_kind;

`ifndef SYNTHESIS
    a_done_has_both: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_search_done |-> (r_found_in != '0 && r_found_out != '0))
        else $error("search done without both endpoints");

    a_done_not_malformed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_search_done && r_malformed))
        else $error("search done and malformed together");

    a_last_clears_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in_item.last_byte) |=>
        (r_byte_offset == '0 && r_kind == ucdef_pkg::KIND_UNKNOWN
         && !r_search_done && !r_malformed && r_out_valid))
        else $error("set state not cleared after last byte");

    a_malformed_no_eps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == ucdef_pkg::STATUS_MALFORMED) |->
        (r_out_in_ep == '0 && r_out_out_ep == '0))
        else $error("malformed result carries endpoints");
`endif

endmodule

>>> tb/sv/tb_top.sv
module tb_top;

    typedef struct packed {
        ucdef_pkg::t_status status;
        logic [7:0]         in_ep;
        logic [7:0]         out_ep;
        ucdef_pkg::t_kind   kind;
    } t_report;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           cfg_we;
    logic [ucdef_pkg::CfgIdxW-1:0]  cfg_index;
    logic [ucdef_pkg::CfgDataW-1:0] cfg_data;

    ucdef_in_if  byte_ch ();
    ucdef_out_if report_ch ();

    usb_config_descriptor_endpoint_finder DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_item   (byte_ch),
        .o_out_item  (report_ch)
    );

    // own copy of the id registers and the descriptor walk
    logic [15:0]      vendor_id;
    logic [15:0]      product_id;
    logic [7:0]       walk_off;
    logic [7:0]       walk_len;
    logic [7:0]       walk_type;
    logic [7:0]       walk_addr;
    logic [7:0]       walk_in;
    logic [7:0]       walk_out;
    ucdef_pkg::t_kind walk_kind;
    logic             walk_done;
    logic             walk_bad;

    t_report     expected_reports[$];
    logic [7:0]  set_bytes[$];
    int          mismatch_count;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          hold_cycles;
    int          bytes_sent;

    initial begin
        i_clk = 1'b0;
    end

    always #1 i_clk = ~i_clk;

    function automatic ucdef_pkg::t_kind ids_to_kind();
        ucdef_pkg::t_kind k;
        k = ucdef_pkg::KIND_UNKNOWN;
        if (vendor_id == ucdef_pkg::CDC_VENDOR && product_id == ucdef_pkg::CDC_PRODUCT) begin
            k = ucdef_pkg::KIND_CDC;
        end else if (vendor_id == ucdef_pkg::BRIDGE_VENDOR
                     && product_id == ucdef_pkg::BRIDGE_PRODUCT) begin
            k = ucdef_pkg::KIND_BRIDGE;
        end
        return k;
    endfunction

    function automatic void clear_walk();
        walk_off  = 8'd0;
        walk_len  = 8'd0;
        walk_type = 8'd0;
        walk_addr = 8'd0;
        walk_in   = 8'd0;
        walk_out  = 8'd0;
        walk_kind = ucdef_pkg::KIND_UNKNOWN;
        walk_done = 1'b0;
        walk_bad  = 1'b0;
    endfunction

    function automatic void walk_byte(input logic [7:0] b, input logic is_last);
        t_report r;
        logic    at_end;
        at_end = 1'b1;
        if (!walk_done && !walk_bad) begin
            if (walk_off == ucdef_pkg::OFF_LENGTH && b < ucdef_pkg::MIN_DESC_LENGTH) begin
                walk_len = b;
                walk_bad = 1'b1;
                at_end = 1'b0;
            end else begin
                case (walk_off)
                    ucdef_pkg::OFF_LENGTH: walk_len = b;
                    ucdef_pkg::OFF_TYPE: begin
                        walk_type = b;
                        if (b == ucdef_pkg::DESC_TYPE_INTERFACE) begin
                            walk_kind = ids_to_kind();
                            walk_in = 8'd0;
                            walk_out = 8'd0;
                        end
                    end
                    ucdef_pkg::OFF_ADDRESS: walk_addr = b;
                    ucdef_pkg::OFF_ATTR: begin
                        if (walk_type == ucdef_pkg::DESC_TYPE_ENDPOINT
                                && walk_kind != ucdef_pkg::KIND_UNKNOWN
                                && b == ucdef_pkg::ATTR_BULK) begin
                            if (walk_addr[7]) begin
                                if (walk_in == 8'd0) walk_in = walk_addr;
                            end else begin
                                if (walk_out == 8'd0) walk_out = walk_addr;
                            end
                        end
                    end
                    default: ;
                endcase
                if (int'(walk_off) + 1 >= int'(walk_len)) begin
                    walk_off = 8'd0;
                    at_end = 1'b1;
                end else begin
                    walk_off = walk_off + 8'd1;
                    at_end = 1'b0;
                end
            end
            if (at_end && !walk_bad && walk_in != 8'd0 && walk_out != 8'd0) begin
                walk_done = 1'b1;
            end
        end
        if (is_last) begin
            if (walk_done) begin
                r = '{status: ucdef_pkg::STATUS_FOUND, in_ep: walk_in, out_ep: walk_out,
                      kind: walk_kind};
            end else if (walk_bad || !at_end) begin
                r = '{status: ucdef_pkg::STATUS_MALFORMED, in_ep: 8'd0, out_ep: 8'd0,
                      kind: walk_kind};
            end else begin
                r = '{status: ucdef_pkg::STATUS_NOT_FOUND, in_ep: walk_in, out_ep: walk_out,
                      kind: walk_kind};
            end
            expected_reports.push_back(r);
            clear_walk();
        end
    endfunction

    // receiver side, with an optional long hold-off
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            report_ch.ready <= 1'b0;
            hold_cycles = hold_cycles - 1;
        end else begin
            report_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin : check_report
        t_report want;
        if (i_rst_n && report_ch.valid && report_ch.ready) begin
            if (expected_reports.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("unexpected report: status %0d in %h out %h kind %0d",
                             report_ch.status, report_ch.in_endpoint,
                             report_ch.out_endpoint, report_ch.device_kind);
                end
            end else begin
                want = expected_reports.pop_front();
                if (report_ch.status !== want.status || report_ch.in_endpoint !== want.in_ep
                        || report_ch.out_endpoint !== want.out_ep
                        || report_ch.device_kind !== want.kind) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("report differs: expected %0d/%h/%h/%0d got %0d/%h/%h/%0d",
                                 want.status, want.in_ep, want.out_ep, want.kind,
                                 report_ch.status, report_ch.in_endpoint,
                                 report_ch.out_endpoint, report_ch.device_kind);
                    end
                end
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic is_last);
        while ($urandom_range(99) < send_idle_pct) begin
            byte_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        byte_ch.valid <= 1'b1;
        byte_ch.data_byte <= b;
        byte_ch.last_byte <= is_last;
        @(posedge i_clk);
        while (!byte_ch.ready) @(posedge i_clk);
        walk_byte(b, is_last);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_set();
        for (int i = 0; i < set_bytes.size(); i++) begin
            send_byte(set_bytes[i], i == set_bytes.size() - 1);
        end
    endtask

    task automatic drain_reports();
        byte_ch.valid <= 1'b0;
        while (expected_reports.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_ids(input logic [15:0] vendor, input logic [15:0] product);
        cfg_we <= 1'b1;
        cfg_index <= ucdef_pkg::CFG_DEVICE_VENDOR;
        cfg_data <= vendor;
        @(negedge i_clk);
        cfg_index <= ucdef_pkg::CFG_DEVICE_PRODUCT;
        cfg_data <= product;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        vendor_id = vendor;
        product_id = product;
    endtask

    task automatic pick_ids();
        case ($urandom_range(7))
            0, 1: set_ids(ucdef_pkg::CDC_VENDOR, ucdef_pkg::CDC_PRODUCT);
            2, 3: set_ids(ucdef_pkg::BRIDGE_VENDOR, ucdef_pkg::BRIDGE_PRODUCT);
            4: set_ids(ucdef_pkg::CDC_VENDOR, 16'($urandom));
            5: set_ids(ucdef_pkg::BRIDGE_VENDOR, ucdef_pkg::CDC_PRODUCT);
            6: set_ids(16'h0000, 16'h0000);
            default: set_ids(16'($urandom), 16'($urandom));
        endcase
    endtask

    function automatic void add_desc(input int len, input logic [7:0] dtype,
                                     input logic [7:0] addr, input logic [7:0] attr);
        set_bytes.push_back(8'(len));
        if (len >= 2) set_bytes.push_back(dtype);
        for (int i = 2; i < len; i++) begin
            set_bytes.push_back(i == 2 ? addr : (i == 3 ? attr : 8'($urandom)));
        end
    endfunction

    function automatic logic [7:0] random_ep_addr();
        if ($urandom_range(3) == 0) return 8'($urandom);
        return {1'($urandom), 3'b000, 4'($urandom)};
    endfunction

    function automatic void build_random_set();
        int shape;
        int cut;
        int len;
        set_bytes.delete();
        shape = $urandom_range(99);
        if (shape < 10) begin
            repeat ($urandom_range(1, 12)) set_bytes.push_back(8'($urandom));
            return;
        end
        if ($urandom_range(1) == 1) add_desc(9, 8'h02, 8'($urandom), 8'($urandom));
        if ($urandom_range(4) != 0) begin
            add_desc($urandom_range(2, 9), ucdef_pkg::DESC_TYPE_INTERFACE,
                     8'($urandom), 8'($urandom));
        end
        repeat ($urandom_range(2, 5)) begin
            case ($urandom_range(9))
                0, 1: add_desc($urandom_range(2, 9), ucdef_pkg::DESC_TYPE_INTERFACE,
                               8'($urandom), 8'($urandom));
                2, 3, 4, 5, 6: begin
                    len = ($urandom_range(3) == 0) ? $urandom_range(2, 6) : 7;
                    add_desc(len, ucdef_pkg::DESC_TYPE_ENDPOINT, random_ep_addr(),
                             ($urandom_range(3) == 0) ? 8'($urandom) : ucdef_pkg::ATTR_BULK);
                end
                7, 8: add_desc($urandom_range(2, 9), 8'($urandom), 8'($urandom), 8'($urandom));
                default: begin
                    len = ($urandom_range(7) == 0) ? $urandom_range(10, 255)
                                                   : $urandom_range(2, 12);
                    add_desc(len, 8'($urandom), 8'($urandom), 8'($urandom));
                end
            endcase
        end
        if (shape >= 85) begin
            case ($urandom_range(2))
                0: begin
                    cut = $urandom_range(1, set_bytes.size());
                    while (set_bytes.size() > cut) void'(set_bytes.pop_back());
                end
                1: begin
                    set_bytes.push_back(8'($urandom_range(1)));
                    repeat ($urandom_range(3)) set_bytes.push_back(8'($urandom));
                end
                default: begin
                    len = $urandom_range(3, 9);
                    set_bytes.push_back(8'(len));
                    repeat ($urandom_range(len - 2)) set_bytes.push_back(8'($urandom));
                end
            endcase
        end
    endfunction

    task automatic test_short_sets();
        set_bytes = '{8'h01};
        send_set();
        set_bytes = '{8'h00};
        send_set();
        set_bytes = '{8'h10};
        send_set();
        drain_reports();
    endtask

    task automatic test_found_and_trailing();
        set_ids(ucdef_pkg::CDC_VENDOR, ucdef_pkg::CDC_PRODUCT);
        set_bytes = '{8'd2, ucdef_pkg::DESC_TYPE_INTERFACE,
                      8'd4, ucdef_pkg::DESC_TYPE_ENDPOINT, 8'hFF, ucdef_pkg::ATTR_BULK,
                      8'd4, ucdef_pkg::DESC_TYPE_ENDPOINT, 8'h7F, ucdef_pkg::ATTR_BULK,
                      8'h00};
        send_set();
        // no interface descriptor, so kind stays unknown
        set_bytes = '{8'd4, ucdef_pkg::DESC_TYPE_ENDPOINT, 8'h81, ucdef_pkg::ATTR_BULK,
                      8'd4, ucdef_pkg::DESC_TYPE_ENDPOINT, 8'h01, ucdef_pkg::ATTR_BULK};
        send_set();
        drain_reports();
    endtask

    task automatic test_rejected_endpoints();
        set_ids(ucdef_pkg::BRIDGE_VENDOR, ucdef_pkg::BRIDGE_PRODUCT);
        set_bytes = '{8'd2, ucdef_pkg::DESC_TYPE_INTERFACE,
                      8'd4, ucdef_pkg::DESC_TYPE_ENDPOINT, 8'h00, ucdef_pkg::ATTR_BULK,
                      8'd4, ucdef_pkg::DESC_TYPE_ENDPOINT, 8'h83, 8'h03,
                      8'd3, ucdef_pkg::DESC_TYPE_ENDPOINT, 8'h84,
                      8'd4, ucdef_pkg::DESC_TYPE_ENDPOINT, 8'h85, ucdef_pkg::ATTR_BULK};
        send_set();
        set_bytes = '{8'd2, ucdef_pkg::DESC_TYPE_INTERFACE, 8'd4, ucdef_pkg::DESC_TYPE_ENDPOINT};
        send_set();
        drain_reports();
    endtask

    task automatic test_unknown_kind();
        set_ids(16'hFFFF, 16'hFFFF);
        set_bytes = '{8'd2, ucdef_pkg::DESC_TYPE_INTERFACE,
                      8'd4, ucdef_pkg::DESC_TYPE_ENDPOINT, 8'h81, ucdef_pkg::ATTR_BULK,
                      8'd4, ucdef_pkg::DESC_TYPE_ENDPOINT, 8'h01, ucdef_pkg::ATTR_BULK};
        send_set();
        drain_reports();
    endtask

    task automatic test_back_pressure();
        drain_reports();
        set_ids(ucdef_pkg::CDC_VENDOR, ucdef_pkg::CDC_PRODUCT);
        @(posedge i_clk);
        hold_cycles = 400;
        @(negedge i_clk);
        repeat (6) begin
            set_bytes = '{8'd2, ucdef_pkg::DESC_TYPE_INTERFACE,
                          8'd4, ucdef_pkg::DESC_TYPE_ENDPOINT,
                          random_ep_addr(), ucdef_pkg::ATTR_BULK};
            send_set();
        end
        drain_reports();
    endtask

    task automatic test_random_traffic(input int target);
        int start;
        int sets_left;
        start = bytes_sent;
        sets_left = 0;
        while (bytes_sent - start < target) begin
            if (sets_left == 0) begin
                drain_reports();
                pick_ids();
                sets_left = $urandom_range(4, 8);
            end
            build_random_set();
            send_set();
            sets_left--;
        end
        drain_reports();
    endtask

    initial begin
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        byte_ch.valid = 1'b0;
        byte_ch.data_byte = 8'd0;
        byte_ch.last_byte = 1'b0;
        report_ch.ready = 1'b0;
        hold_cycles = 0;
        mismatch_count = 0;
        bytes_sent = 0;
        vendor_id = 16'd0;
        product_id = 16'd0;
        clear_walk();
        send_idle_pct = 12;
        recv_idle_pct = 58;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_short_sets();
        test_found_and_trailing();
        test_rejected_endpoints();
        test_unknown_kind();
        test_back_pressure();
        test_random_traffic(600);

        send_idle_pct = 58;
        recv_idle_pct = 12;
        test_random_traffic(600);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(600);

        repeat (8) @(negedge i_clk);
        if (mismatch_count == 0) begin
            $display("usb_config_descriptor_endpoint_finder: match");
        end else begin
            $display("usb_config_descriptor_endpoint_finder: mismatch");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("usb_config_descriptor_endpoint_finder: mismatch");
        $finish;
    end

endmodule
